>>> rtl/pcsq_pkg.sv
// Package for the priority command slot queue.
// Holds slot constants, code constants, payload structs and control types.
// No dependencies.
package pcsq_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = 2;
    localparam int CNT_W      = SLOT_W + 1;

    // command codes
    localparam logic [1:0] CMD_SUBMIT   = 2'd0;
    localparam logic [1:0] CMD_DRAIN    = 2'd1;
    localparam logic [1:0] CMD_COMPLETE = 2'd2;
    localparam logic [1:0] CMD_COLLECT  = 2'd3;

    // outcome codes
    localparam logic [3:0] OC_QUEUED    = 4'd0;
    localparam logic [3:0] OC_MERGED    = 4'd1;
    localparam logic [3:0] OC_FULL      = 4'd2;
    localparam logic [3:0] OC_STALE     = 4'd3;
    localparam logic [3:0] OC_FREED     = 4'd4;
    localparam logic [3:0] OC_SIGNALLED = 4'd5;
    localparam logic [3:0] OC_COLLECTED = 4'd6;
    localparam logic [3:0] OC_TIMEOUT   = 4'd7;
    localparam logic [3:0] OC_DISPATCH  = 4'd8;

    // receipt status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_FAILED   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_STOP_KIND    = 2'd0;
    localparam logic [1:0] CFG_BUSY_EFFECT  = 2'd1;
    localparam logic [1:0] CFG_TMO_EFFECT   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  cmd_kind;
        logic        wait_for_result;
        logic [63:0] given_request_id;
        logic [1:0]  slot_in;
        logic [31:0] generation_in;
        logic        verdict_allowed;
        logic        effect_failed;
        logic [7:0]  reject_code_in;
        logic [7:0]  effect_code_in;
        logic        timed_out;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  outcome;
        logic [1:0]  slot_out;
        logic [31:0] generation_out;
        logic [63:0] request_id_out;
        logic [7:0]  kind_out;
        logic        preempted;
        logic [7:0]  evicted_kind;
        logic [63:0] evicted_request_id;
        logic [2:0]  receipt_status;
        logic [7:0]  reject_code_out;
        logic [7:0]  effect_code_out;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
        logic next;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_drain;
        logic drain_empty;
        logic drain_last;
    } t_dp_status;

endpackage

>>> rtl/pcsq_ctrl.sv
// Controller state machine of the priority command slot queue.
// Depends on pcsq_pkg for the state and command/status types.
module pcsq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    input  pcsq_pkg::t_dp_status  i_status,
    output pcsq_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);

    pcsq_pkg::t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcsq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcsq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pcsq_pkg::S_EXEC;
            end
            pcsq_pkg::S_EXEC: begin
                if (!i_status.is_drain)        n_state = pcsq_pkg::S_OUT;
                else if (i_status.drain_empty) n_state = pcsq_pkg::S_IDLE;
                else                           n_state = pcsq_pkg::S_EMIT;
            end
            pcsq_pkg::S_EMIT: begin
                n_state = pcsq_pkg::S_OUT;
            end
            pcsq_pkg::S_OUT: begin
                if (i_out_ready) begin
                    if (i_status.is_drain && !i_status.drain_last) n_state = pcsq_pkg::S_EMIT;
                    else                                           n_state = pcsq_pkg::S_IDLE;
                end
            end
            default: n_state = pcsq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pcsq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pcsq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            pcsq_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            pcsq_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.next  = i_out_ready && i_status.is_drain && !i_status.drain_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/pcsq_dp.sv
// Datapath of the priority command slot queue: slot table, counters,
// configuration registers, drain list and result register. Uses pcsq_pkg.
module pcsq_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcsq_pkg::t_dp_cmd     i_cmd,
    output pcsq_pkg::t_dp_status  o_status,
    input  pcsq_pkg::t_in_item    i_in_data,
    output pcsq_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    localparam int N = pcsq_pkg::SLOT_COUNT;
    localparam int SW = pcsq_pkg::SLOT_W;
    localparam int CW = pcsq_pkg::CNT_W;

    pcsq_pkg::t_in_item  r_in;
    pcsq_pkg::t_out_item r_out, n_out;
    logic [7:0]  r_stop, r_busy, r_tmo;
    logic        r_used [N];
    logic        n_used [N];
    logic        r_wait [N];
    logic        n_wait [N];
    logic [31:0] r_gen  [N];
    logic [31:0] n_gen  [N];
    logic [7:0]  r_kind [N];
    logic [7:0]  n_kind [N];
    logic [63:0] r_rid  [N];
    logic [63:0] n_rid  [N];
    logic [2:0]  r_rst  [N];
    logic [2:0]  n_rst  [N];
    logic [7:0]  r_rej  [N];
    logic [7:0]  n_rej  [N];
    logic [7:0]  r_eff  [N];
    logic [7:0]  n_eff  [N];
    logic [31:0] r_gcnt, n_gcnt;
    logic [63:0] r_rcnt, n_rcnt;
    logic [SW-1:0] r_order [N];
    logic [SW-1:0] n_order [N];
    logic [CW-1:0] r_n, n_n, r_j, n_j;

    logic [SW-1:0] rd_idx;
    logic          rd_used, rd_wait;
    logic [31:0]   rd_gen;
    logic [7:0]    rd_kind;
    logic [63:0]   rd_rid;
    logic [2:0]    rd_rst;
    logic [7:0]    rd_rej, rd_eff;

    // single read port of the slot table
    assign rd_idx  = i_cmd.emit ? r_order[r_j[SW-1:0]] : r_in.slot_in;
    assign rd_used = r_used[rd_idx];
    assign rd_wait = r_wait[rd_idx];
    assign rd_gen  = r_gen[rd_idx];
    assign rd_kind = r_kind[rd_idx];
    assign rd_rid  = r_rid[rd_idx];
    assign rd_rst  = r_rst[rd_idx];
    assign rd_rej  = r_rej[rd_idx];
    assign rd_eff  = r_eff[rd_idx];

    // the list length is judged while the drain executes, from the fresh count
    assign o_status.is_drain    = (r_in.cmd == pcsq_pkg::CMD_DRAIN);
    assign o_status.drain_empty = (n_n == '0);
    assign o_status.drain_last  = ((r_j + CW'(1)) == r_n);
    assign o_out_data = r_out;

    // execute the request or emit one drain entry
    always_comb begin
        logic          prio, m_hit, f_hit, p0_hit, p1_hit, cur, do_fill;
        logic [SW-1:0] m_i, f_i, p0_i, p1_i, t_i;
        logic [63:0]   m_rid, p0_rid, p1_rid, rid;
        logic [31:0]   m_gen;
        logic [7:0]    p0_kind, p1_kind;
        logic [2:0]    st;
        logic [7:0]    eff;
        logic [CW-1:0] cnt;

        n_out   = r_out;
        n_gcnt  = r_gcnt;
        n_rcnt  = r_rcnt;
        n_order = r_order;
        n_n     = r_n;
        n_j     = r_j;
        for (int i = 0; i < N; i++) begin
            n_used[i] = r_used[i];
            n_wait[i] = r_wait[i];
            n_gen[i]  = r_gen[i];
            n_kind[i] = r_kind[i];
            n_rid[i]  = r_rid[i];
            n_rst[i]  = r_rst[i];
            n_rej[i]  = r_rej[i];
            n_eff[i]  = r_eff[i];
        end

        prio  = (r_in.cmd_kind == r_stop);
        m_hit = 1'b0; f_hit = 1'b0; p0_hit = 1'b0; p1_hit = 1'b0;
        m_i = '0; f_i = '0; p0_i = '0; p1_i = '0; t_i = '0;
        m_rid = '0; p0_rid = '0; p1_rid = '0; m_gen = '0;
        p0_kind = '0; p1_kind = '0;
        do_fill = 1'b0;
        cnt = '0;

        // scan slots for merge, free and preemption candidates
        for (int i = 0; i < N; i++) begin
            if (!m_hit && r_used[i] && r_kind[i] == r_in.cmd_kind && !r_wait[i]) begin
                m_hit = 1'b1; m_i = SW'(i); m_rid = r_rid[i]; m_gen = r_gen[i];
            end
            if (!f_hit && !r_used[i]) begin
                f_hit = 1'b1; f_i = SW'(i);
            end
            if (!p0_hit && r_used[i] && r_kind[i] != r_stop && !r_wait[i]) begin
                p0_hit = 1'b1; p0_i = SW'(i); p0_kind = r_kind[i]; p0_rid = r_rid[i];
            end
            if (!p1_hit && r_used[i] && r_kind[i] != r_stop) begin
                p1_hit = 1'b1; p1_i = SW'(i); p1_kind = r_kind[i]; p1_rid = r_rid[i];
            end
        end

        rid = (r_in.given_request_id != '0) ? r_in.given_request_id : (r_rcnt + 64'd1);
        cur = rd_used && (rd_gen == r_in.generation_in);

        if (r_in.verdict_allowed == 1'b0) begin
            st = pcsq_pkg::ST_REJECTED; eff = '0;
        end else if (r_in.effect_failed) begin
            st = pcsq_pkg::ST_FAILED;   eff = r_in.effect_code_in;
        end else begin
            st = pcsq_pkg::ST_ACCEPTED; eff = '0;
        end

        if (i_cmd.exec) begin
            n_out      = '0;
            n_out.last = 1'b1;
            case (r_in.cmd)
                pcsq_pkg::CMD_SUBMIT: begin
                    if (r_in.given_request_id == '0) n_rcnt = r_rcnt + 64'd1;
                    n_out.request_id_out  = rid;
                    n_out.kind_out        = r_in.cmd_kind;
                    n_out.receipt_status  = pcsq_pkg::ST_BUSY;
                    n_out.effect_code_out = r_busy;
                    if (prio && m_hit) begin
                        n_out.outcome        = pcsq_pkg::OC_MERGED;
                        n_out.request_id_out = m_rid;
                        if (r_in.wait_for_result) begin
                            n_wait[m_i]          = 1'b1;
                            n_out.slot_out       = m_i;
                            n_out.generation_out = m_gen;
                        end
                    end else if (f_hit) begin
                        do_fill = 1'b1; t_i = f_i;
                    end else if (prio && p0_hit) begin
                        do_fill = 1'b1; t_i = p0_i;
                        n_out.preempted          = 1'b1;
                        n_out.evicted_kind       = p0_kind;
                        n_out.evicted_request_id = p0_rid;
                    end else if (prio && p1_hit) begin
                        do_fill = 1'b1; t_i = p1_i;
                        n_out.preempted          = 1'b1;
                        n_out.evicted_kind       = p1_kind;
                        n_out.evicted_request_id = p1_rid;
                    end else begin
                        n_out.outcome = pcsq_pkg::OC_FULL;
                    end
                    // claim a slot with a fresh generation
                    if (do_fill) begin
                        n_gcnt               = r_gcnt + 32'd1;
                        n_used[t_i]          = 1'b1;
                        n_wait[t_i]          = r_in.wait_for_result;
                        n_gen[t_i]           = n_gcnt;
                        n_kind[t_i]          = r_in.cmd_kind;
                        n_rid[t_i]           = rid;
                        n_rst[t_i]           = pcsq_pkg::ST_BUSY;
                        n_rej[t_i]           = '0;
                        n_eff[t_i]           = r_busy;
                        n_out.outcome        = pcsq_pkg::OC_QUEUED;
                        n_out.slot_out       = t_i;
                        n_out.generation_out = n_gcnt;
                    end
                end
                pcsq_pkg::CMD_DRAIN: begin
                    // list stop slots first, then the rest
                    for (int i = 0; i < N; i++) begin
                        if (r_used[i] && r_kind[i] == r_stop) begin
                            n_order[cnt[SW-1:0]] = SW'(i);
                            cnt = cnt + CW'(1);
                        end
                    end
                    for (int i = 0; i < N; i++) begin
                        if (r_used[i] && r_kind[i] != r_stop) begin
                            n_order[cnt[SW-1:0]] = SW'(i);
                            cnt = cnt + CW'(1);
                        end
                    end
                    n_n = cnt;
                    n_j = '0;
                end
                pcsq_pkg::CMD_COMPLETE: begin
                    n_out.slot_out       = r_in.slot_in;
                    n_out.generation_out = r_in.generation_in;
                    if (!cur) begin
                        n_out.outcome = pcsq_pkg::OC_STALE;
                    end else begin
                        n_rst[r_in.slot_in]   = st;
                        n_rej[r_in.slot_in]   = r_in.reject_code_in;
                        n_eff[r_in.slot_in]   = eff;
                        n_out.outcome         = rd_wait ? pcsq_pkg::OC_SIGNALLED
                                                        : pcsq_pkg::OC_FREED;
                        n_out.request_id_out  = rd_rid;
                        n_out.kind_out        = rd_kind;
                        n_out.receipt_status  = st;
                        n_out.reject_code_out = r_in.reject_code_in;
                        n_out.effect_code_out = eff;
                        if (!rd_wait) n_used[r_in.slot_in] = 1'b0;
                    end
                end
                pcsq_pkg::CMD_COLLECT: begin
                    n_out.slot_out       = r_in.slot_in;
                    n_out.generation_out = r_in.generation_in;
                    if (cur) begin
                        n_used[r_in.slot_in] = 1'b0;
                        n_wait[r_in.slot_in] = 1'b0;
                        n_out.request_id_out = rd_rid;
                        n_out.kind_out       = rd_kind;
                    end
                    if (r_in.timed_out || !cur) begin
                        n_out.outcome         = pcsq_pkg::OC_TIMEOUT;
                        n_out.receipt_status  = pcsq_pkg::ST_TIMEOUT;
                        n_out.effect_code_out = r_tmo;
                    end else begin
                        n_out.outcome         = pcsq_pkg::OC_COLLECTED;
                        n_out.receipt_status  = rd_rst;
                        n_out.reject_code_out = rd_rej;
                        n_out.effect_code_out = rd_eff;
                    end
                end
                default: n_out.outcome = pcsq_pkg::OC_STALE;
            endcase
        end else if (i_cmd.emit) begin
            n_out                = '0;
            n_out.outcome        = pcsq_pkg::OC_DISPATCH;
            n_out.slot_out       = rd_idx;
            n_out.generation_out = rd_gen;
            n_out.request_id_out = rd_rid;
            n_out.kind_out       = rd_kind;
            n_out.last           = ((r_j + CW'(1)) == r_n);
        end

        if (i_cmd.next) n_j = r_j + CW'(1);
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop <= '0;
            r_busy <= '0;
            r_tmo  <= '0;
            r_gcnt <= '0;
            r_rcnt <= '0;
            r_n    <= '0;
            r_j    <= '0;
            for (int i = 0; i < N; i++) begin
                r_used[i] <= 1'b0;
                r_wait[i] <= 1'b0;
                r_gen[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pcsq_pkg::CFG_STOP_KIND:   r_stop <= i_cfg_data;
                    pcsq_pkg::CFG_BUSY_EFFECT: r_busy <= i_cfg_data;
                    pcsq_pkg::CFG_TMO_EFFECT:  r_tmo  <= i_cfg_data;
                    default: r_stop <= r_stop;
                endcase
            end
            r_gcnt <= n_gcnt;
            r_rcnt <= n_rcnt;
            r_n    <= n_n;
            r_j    <= n_j;
            for (int i = 0; i < N; i++) begin
                r_used[i] <= n_used[i];
                r_wait[i] <= n_wait[i];
                r_gen[i]  <= n_gen[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        r_out   <= n_out;
        r_order <= n_order;
        for (int i = 0; i < N; i++) begin
            r_kind[i] <= n_kind[i];
            r_rid[i]  <= n_rid[i];
            r_rst[i]  <= n_rst[i];
            r_rej[i]  <= n_rej[i];
            r_eff[i]  <= n_eff[i];
        end
    end

endmodule

>>> rtl/priority_command_slot_queue.sv
// Top level of the priority command slot queue.
// Joins pcsq_ctrl and pcsq_dp; types from pcsq_pkg.
//
//   Channel   Direction  Handshake                Payload
//   in        to block   i_in_valid/o_in_ready    i_in_data  (t_in_item)
//   out       from block o_out_valid/i_out_ready  o_out_data (t_out_item)
//   cfg       to block   i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// Submit, complete and collect pass accept, execute and present; a stalled
// result holds. A drain passes accept and execute, then the controller
// walks the list one entry per result. One request is in flight at a time.
// Reset clears the slot flags, generations and both counters at once.
// Configuration writes are always taken.
module priority_command_slot_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pcsq_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pcsq_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    pcsq_pkg::t_dp_cmd    w_cmd;
    pcsq_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    pcsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    pcsq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

>>> rtl/pcsq_checker.sv
// Port-level checker for the priority command slot queue, bound to the top.
// Uses pcsq_pkg for the payload types.
module pcsq_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input pcsq_pkg::t_out_item  o_out_data
);

    // one request at a time: no new request while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request taken while a result is pending");

    // an accepted request closes the input side for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // a result not marked last is followed by more results, not a new request
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last) |=> !o_in_ready)
        else $error("drain list cut short");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind priority_command_slot_queue pcsq_checker u_pcsq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
